/* sv/unique_value_fifo_queue_defines.svh */
// Assertion helpers used by the RTL of the unique value queue.
`ifndef UNIQUE_VALUE_FIFO_QUEUE_DEFINES_SVH
`define UNIQUE_VALUE_FIFO_QUEUE_DEFINES_SVH

// Clocked check that is switched off while reset is high.
`define UVFQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define UVFQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/uvfq_pkg.sv */
package uvfq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - COUNT_W - 1;

  // Operation codes carried in the input tuser.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes carried in the output tuser.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

endpackage

/* sv/uvfq_ram.sv */
module uvfq_ram import uvfq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port and one registered read port; read data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/unique_value_fifo_queue.sv */
// Channel   Direction  Ports                          Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser  value_in, operation
// m_*       out        m_tvalid m_tready m_tdata m_tuser  value_out, count, empty; status
//
// An enqueue against live entries first scans them one by one, since the single comparator sees
// one stored entry per cycle through the registered RAM read, then commits and loads the output
// register. An enqueue on an empty queue skips the scan; a dequeue reads the head in S_DEQ,
// and an empty dequeue goes straight to the output state. s_tready is high only while idle.
// rst is synchronous and active high; it empties the queue and drops m_tvalid.
// A result waiting on m_tready holds the sequencer in its output state.
`include "unique_value_fifo_queue_defines.svh"

module unique_value_fifo_queue import uvfq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value_in
  input  logic                   s_tuser,   // [0] operation
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] value_out, [36:32] entry_count,
                                            // [37] is_empty, [39:38] zero
  output logic [STATUS_W-1:0]    m_tuser    // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_DEQ    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]          state;
  logic                op;
  logic [DATA_W-1:0]   value;
  logic [AW-1:0]       head;
  logic [AW-1:0]       tail;
  logic [CW-1:0]       held;
  logic [AW-1:0]       rd_ptr;
  logic [CW-1:0]       issue_left;
  logic                cmp_pend;
  logic [STATUS_W-1:0] res_status;
  logic [DATA_W-1:0]   res_value;
  logic [CW-1:0]       res_count;

  logic                accept;
  logic [AW-1:0]       rd_addr;
  logic [DATA_W-1:0]   rd_data;
  logic                match;
  logic                mem_we;
  logic                is_full;
  logic                out_load;
  logic                empty_out;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (held == CW'(DEPTH));

  // While idle the read port looks at the head, so a dequeue has its data in the
  // cycle after the transfer. During a scan it walks from head to tail.
  assign rd_addr  = (state == S_IDLE) ? head : rd_ptr;
  assign match    = cmp_pend && (rd_data == value);
  assign mem_we   = (state == S_COMMIT) && !is_full;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  assign empty_out = m_tvalid && (m_tuser == STATUS_EMPTY);

  uvfq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(tail),
    .wdata(value),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      held       <= '0;
      issue_left <= '0;
      cmp_pend   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            issue_left <= held;
            cmp_pend   <= 1'b0;
            if (s_tuser == OP_DEQUEUE) begin
              state <= (held == '0) ? S_OUT : S_DEQ;
            end else begin
              state <= (held == '0) ? S_COMMIT : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // One read issued and one stored value compared per cycle.
          if (match) begin
            state <= S_OUT;
          end else if (issue_left != '0) begin
            issue_left <= issue_left - 1'b1;
            cmp_pend   <= 1'b1;
          end else begin
            cmp_pend <= 1'b0;
            state    <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (!is_full) begin
            tail <= ring_inc(tail);
            held <= held + 1'b1;
          end
          state <= S_OUT;
        end
        S_DEQ: begin
          head  <= ring_inc(head);
          held  <= held - 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A new result replaces one that leaves in the same cycle.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op         <= s_tuser;
          value      <= s_tdata;
          rd_ptr     <= head;
          res_status <= STATUS_EMPTY;
          res_value  <= '0;
          res_count  <= held;
        end
      end
      S_SCAN: begin
        if (match) begin
          res_status <= STATUS_DUP;
          res_count  <= held;
        end else if (issue_left != '0) begin
          rd_ptr <= ring_inc(rd_ptr);
        end
      end
      S_COMMIT: begin
        res_status <= is_full ? STATUS_FULL : STATUS_DONE;
        res_count  <= is_full ? held : held + 1'b1;
      end
      S_DEQ: begin
        res_status <= STATUS_DONE;
        res_value  <= rd_data;
        res_count  <= held - 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {OUT_PAD_W'(0), (res_count == '0), COUNT_W'(res_count), res_value};
    end
  end

  `UVFQ_ASSERT(a_count_in_range, (held <= CW'(DEPTH)), "entry count exceeds depth")
  `UVFQ_ASSERT(a_busy_after_transfer, (accept |=> !s_tready), "ready during an operation")
  `UVFQ_ASSERT(a_empty_ring_aligned, ((held == '0) |-> (head == tail)), "head and tail apart")
  `UVFQ_ASSERT(a_empty_result_zero, (empty_out |-> (m_tdata[DATA_W-1:0] == '0)), "empty data")
  `UVFQ_ASSERT(a_write_not_dup, (mem_we |-> !match), "duplicate written")

endmodule

/* bench/uvfq_result_checker.sv */
`timescale 1ns / 100ps

module uvfq_result_checker import uvfq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [DATA_W-1:0]      s_tdata,   // [31:0] value_in
  input  logic                   s_tuser,   // [0] operation
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] value_out, [36:32] entry_count,
                                            // [37] is_empty, [39:38] zero
  input  logic [STATUS_W-1:0]    m_tuser,   // [1:0] status
  output int                     fail_count,
  output int                     pending,
  output int                     done_seen,
  output int                     dup_seen,
  output int                     empty_seen,
  output int                     full_seen
);

  localparam int RING      = DEPTH_DEF;
  localparam int COUNT_LSB = DATA_W;
  localparam int EMPTY_BIT = DATA_W + COUNT_W;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value;
    logic [COUNT_W-1:0]       count;
    logic                     empty;
  } queue_result_t;

  // Shadow copy of the ring and its pointers.
  logic [DATA_W-1:0] ring_vals [RING];
  int                head_pos;
  int                tail_pos;
  int                held;

  queue_result_t expected_q [$];
  int            mismatches;
  int            n_done, n_dup, n_empty, n_full;

  // Applies one operation to the shadow queue and returns the result it must produce.
  function automatic queue_result_t apply_queue_op(logic op, logic [DATA_W-1:0] val);
    queue_result_t r;
    int            pos;
    int            k;
    logic          hit;
    r   = '0;
    hit = 1'b0;
    if (op == OP_ENQUEUE) begin
      pos = head_pos;
      for (k = 0; k < held; k++) begin
        if (ring_vals[pos] == val) hit = 1'b1;
        pos = (pos + 1) % RING;
      end
      // A duplicate wins over a full ring.
      if (hit) begin
        r.status = STATUS_DUP;
      end else if (held == RING) begin
        r.status = STATUS_FULL;
      end else begin
        ring_vals[tail_pos] = val;
        tail_pos = (tail_pos + 1) % RING;
        held++;
        r.status = STATUS_DONE;
      end
    end else begin
      if (held == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.value  = ring_vals[head_pos];
        head_pos = (head_pos + 1) % RING;
        held--;
        r.status = STATUS_DONE;
      end
    end
    r.count = COUNT_W'(held);
    r.empty = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, queue_result_t want, queue_result_t seen);
    if (mismatches < 10) begin
      $display("%0t: mismatch, %s: expected status %0d value %0d count %0d empty %0d,", $time,
               what, want.status, $signed(want.value), want.count, want.empty);
      $display("    got status %0d value %0d count %0d empty %0d", seen.status,
               $signed(seen.value), seen.count, seen.empty);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    queue_result_t seen;
    queue_result_t want;
    if (rst) begin
      head_pos = 0;
      tail_pos = 0;
      held     = 0;
      expected_q.delete();
    end else begin
      // The result leaving in this cycle always belongs to an earlier input transfer,
      // so it is checked before this cycle's input is predicted.
      if (m_tvalid && m_tready) begin
        seen.status = m_tuser;
        seen.value  = m_tdata[DATA_W-1:0];
        seen.count  = m_tdata[COUNT_LSB +: COUNT_W];
        seen.empty  = m_tdata[EMPTY_BIT];
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, seen);
        end else begin
          want = expected_q.pop_front();
          if (seen != want) report_mismatch("wrong field", want, seen);
          case (want.status)
            STATUS_DONE:  n_done++;
            STATUS_DUP:   n_dup++;
            STATUS_EMPTY: n_empty++;
            default:      n_full++;
          endcase
        end
      end
      if (s_tvalid && s_tready) expected_q.push_back(apply_queue_op(s_tuser, s_tdata));
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
    done_seen  <= n_done;
    dup_seen   <= n_dup;
    empty_seen <= n_empty;
    full_seen  <= n_full;
  end

endmodule

/* bench/tb_unique_value_fifo_queue.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the duplicate-rejecting queue. The checker beside the
// block predicts and compares every result; this module only decides what is sent,
// when the receiver stalls, and whether the run passed.
module tb_unique_value_fifo_queue;
  import uvfq_pkg::*;

  // Roughly 1900 items, plus gaps, stalls and the long hold-off, stay well under the
  // limit, which leaves a wide margin on top.
  localparam int CYCLE_LIMIT    = 600000;
  localparam int ITEM_TOTAL     = 1900;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RECENT_KEEP    = 24;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata  = '0;   // [31:0] value_in
  logic                   s_tuser  = OP_ENQUEUE;   // [0] operation
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] value_out, [36:32] entry_count, [37] is_empty
  logic [STATUS_W-1:0]    m_tuser;   // [1:0] status

  int fail_count, pending, done_seen, dup_seen, empty_seen, full_seen;

  int          cycle_count   = 0;
  int          holdoff_asked = 0;
  int          holdoff_served = 0;
  int          burst_left    = 0;
  int          items_sent    = 0;
  int          enq_sent      = 0;
  int          deq_sent      = 0;
  logic [DATA_W-1:0] recent_values [$];

  unique_value_fifo_queue #(.DEPTH(DEPTH_DEF)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  uvfq_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .done_seen  (done_seen),
    .dup_seen   (dup_seen),
    .empty_seen (empty_seen),
    .full_seen  (full_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("unique_value_fifo_queue test failed");
      $finish;
    end
  end

  // Receiver. It runs through segments of different stall patterns: always ready,
  // coin flips, mostly stalled, and a fixed period. When the stimulus asks for a
  // hold-off it drops m_tready for a long, counted stretch so that the block backs
  // up and has to stall its input.
  initial begin : receiver
    int mode;
    int seg;
    int period;
    int k;
    forever begin
      mode   = $urandom_range(0, 3);
      seg    = $urandom_range(20, 150);
      period = $urandom_range(2, 6);
      for (k = 0; k < seg && holdoff_asked == holdoff_served; k++) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (k % period == 0);
        endcase
        @(posedge clk);
      end
      if (holdoff_asked != holdoff_served) begin
        holdoff_served++;
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
    end
  end

  // Offers one item and returns at the edge where it is transferred. The sender
  // works in bursts; a new burst starts after a random gap, and some bursts are
  // long so that stretches without any idling occur too. tvalid is left high on
  // return so that back-to-back items never lower and raise it in one step.
  task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == OP_ENQUEUE) begin
      enq_sent++;
      recent_values.push_back(val);
      if (recent_values.size() > RECENT_KEEP) void'(recent_values.pop_front());
    end else begin
      deq_sent++;
    end
  endtask

  // Stops offering and waits until every outstanding result has been taken.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Values for an enqueue. Recently sent values and a narrow band around zero make
  // duplicates common; the extremes and fully random words cover every data bit.
  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30 && recent_values.size() > 0)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    else if (sel < 55)
      return DATA_W'($urandom_range(0, 40));
    else if (sel < 65)
      return ~DATA_W'($urandom_range(0, 39));
    else if (sel < 72) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    int k;
    int phase;
    int phase_len;
    int enq_pct;
    logic op;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening. A dequeue on the empty queue, then the extremes of value_in.
    send_item(OP_DEQUEUE, 32'hffff_ffff);
    send_item(OP_ENQUEUE, 32'h8000_0000);
    send_item(OP_ENQUEUE, 32'h7fff_ffff);
    send_item(OP_ENQUEUE, 32'h0000_0000);
    send_item(OP_ENQUEUE, 32'hffff_ffff);
    // A live value is refused.
    send_item(OP_ENQUEUE, 32'h7fff_ffff);
    // Once the minimum has left the queue it is accepted again.
    send_item(OP_DEQUEUE, 32'h0);
    send_item(OP_ENQUEUE, 32'h8000_0000);
    // Fill the ring to DEPTH entries.
    for (k = 1; k <= DEPTH_DEF - 4; k++) send_item(OP_ENQUEUE, DATA_W'(k));
    // On a full ring a duplicate is still reported as a duplicate, a new value as full.
    send_item(OP_ENQUEUE, 32'h0000_0000);
    send_item(OP_ENQUEUE, 32'd100);
    send_item(OP_DEQUEUE, 32'h5a5a_a5a5);
    wait_results_drained();

    // Random phases that lean toward filling, draining, or neither, so the ring
    // wraps many times and both the full and the empty ends are reached often.
    phase = 0;
    while (items_sent < ITEM_TOTAL) begin
      phase_len = $urandom_range(10, 70);
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 20;
        default: enq_pct = 55;
      endcase
      for (k = 0; k < phase_len; k++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        send_item(op, (op == OP_ENQUEUE) ? pick_value() : DATA_W'($urandom));
      end
      // Twice in the run the receiver holds off for a long stretch while the sender
      // keeps offering, then the sender waits until every result has arrived.
      if (phase == 5 || phase == 24) begin
        holdoff_asked <= holdoff_asked + 1;
        for (k = 0; k < 30; k++) begin
          op = ($urandom_range(0, 3) != 0) ? OP_ENQUEUE : OP_DEQUEUE;
          send_item(op, (op == OP_ENQUEUE) ? pick_value() : DATA_W'($urandom));
        end
        wait_results_drained();
      end else if ($urandom_range(0, 9) == 0) begin
        wait_results_drained();
      end
      phase++;
    end

    wait_results_drained();
    // This wait covers any stray result, even one from an enqueue on a full ring.
    repeat (60) @(posedge clk);

    $display("Sent %0d items (%0d enqueues, %0d dequeues) over %0d cycles.", items_sent,
             enq_sent, deq_sent, cycle_count);
    $display("Results checked: %0d done, %0d duplicate, %0d empty, %0d full; %0d mismatches.",
             done_seen, dup_seen, empty_seen, full_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("unique_value_fifo_queue test passed");
    end else begin
      $display("unique_value_fifo_queue test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/uvfq_pkg.sv
sv/uvfq_ram.sv
sv/unique_value_fifo_queue.sv
bench/uvfq_result_checker.sv
bench/tb_unique_value_fifo_queue.sv
